// ===== hdl/positional_ordered_list_core_assert.svh =====
// ---------------------------------------------------------------------------
// Positional ordered list core - assertion macros
// Concurrent check macros, clocked on i_clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef POSITIONAL_ORDERED_LIST_CORE_ASSERT_SVH
`define POSITIONAL_ORDERED_LIST_CORE_ASSERT_SVH

// same-cycle implication
`define POLC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication
`define POLC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== hdl/pol_pkg.sv =====
// ---------------------------------------------------------------------------
// Positional ordered list package
// Sizes, opcodes, sequencer states and item types for the list core.
// ---------------------------------------------------------------------------
`default_nettype none

package pol_pkg;

    localparam int CAPACITY     = 64;
    localparam int PAYLOAD_BITS = 32;

    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int POS_W  = 7;
    localparam int CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
    localparam int CODE_W = 32;
    localparam int DATA_W = CODE_W + PAYLOAD_BITS;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_FIND   = 2'd2,
        OP_READ   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT,
        S_PUT,
        S_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [POS_W-1:0]   position;
        logic signed [31:0] record_code;
        logic [31:0]        record_payload;
    } t_cmd;

    typedef struct packed {
        logic               ok;
        logic [POS_W-1:0]   found_position;
        logic signed [31:0] read_code;
        logic [31:0]        read_payload;
        logic [POS_W-1:0]   list_length;
        logic               is_empty;
    } t_res;

endpackage

`default_nettype wire

// ===== hdl/pol_ram.sv =====
// ---------------------------------------------------------------------------
// Positional ordered list record RAM
// Simple dual-port RAM: one write port, one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module pol_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]              o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/positional_ordered_list_core.sv =====
// Insert (p = position) shifts the records from p on up by one, then writes the new one;
// remove shifts the records after p down by one; find scans from the head until a match
// or the end of the list; read fetches one record; a rejected item goes straight to done.
// One item at a time; the next item is accepted from the cycle after the strobe.
// Synchronous active-low reset empties the list; no clearing pass is needed.
// The result is held for the single cycle of o_done; the receiver cannot stall.
// ---------------------------------------------------------------------------
// Positional ordered list core
// Sequencer that shifts, scans and reads records through one dual-port RAM.
// ---------------------------------------------------------------------------
`default_nettype none

`include "positional_ordered_list_core_assert.svh"

module positional_ordered_list_core (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         start,
    input  wire pol_pkg::t_cmd i_cmd,
    output logic              busy,
    output logic              o_done,
    output pol_pkg::t_res     o_result
);

    import pol_pkg::*;

    t_state                  r_state, n_state;
    t_op                     r_op;
    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        r_left;
    logic [IDX_W-1:0]        r_ridx;
    logic [IDX_W-1:0]        r_widx;
    logic [IDX_W-1:0]        r_pidx;
    logic                    r_pend;
    logic [CODE_W-1:0]       r_code;
    logic [PAYLOAD_BITS-1:0] r_pay;
    logic                    r_ok;
    logic [CNT_W-1:0]        r_found;
    logic [DATA_W-1:0]       r_rdata;

    logic                    accept;
    logic [CMP_W-1:0]        pos_c;
    logic [CMP_W-1:0]        cnt_c;
    logic                    ins_ok;
    logic                    pos_ok;
    logic                    issue;
    logic                    hit;
    logic                    ram_we;
    logic [IDX_W-1:0]        ram_waddr;
    logic [DATA_W-1:0]       ram_wdata;
    logic                    ram_re;
    logic [DATA_W-1:0]       ram_rdata;

    assign accept = start && !busy;
    assign pos_c  = CMP_W'(i_cmd.position);
    assign cnt_c  = CMP_W'(r_count);
    assign ins_ok = (pos_c != '0) && (pos_c <= cnt_c + 1'b1)
                    && (r_count < CNT_W'(CAPACITY));
    assign pos_ok = (pos_c != '0) && (pos_c <= cnt_c);
    assign issue  = (r_left != '0);
    assign hit    = r_pend && ((r_op == OP_READ)
                    || (ram_rdata[DATA_W-1:PAYLOAD_BITS] == r_code));

    pol_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_ridx),
        .o_rdata (ram_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (t_op'(i_cmd.opcode))
                        OP_INSERT: n_state = ins_ok ? S_SHIFT : S_DONE;
                        OP_REMOVE: n_state = pos_ok ? S_SHIFT : S_DONE;
                        OP_FIND:   n_state = S_SCAN;
                        OP_READ:   n_state = pos_ok ? S_SCAN : S_DONE;
                    endcase
                end
            end
            S_SHIFT: begin
                if (!issue && !r_pend) begin
                    n_state = (r_op == OP_INSERT) ? S_PUT : S_DONE;
                end
            end
            S_PUT: n_state = S_DONE;
            S_SCAN: begin
                if (hit || (!issue && !r_pend)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // outputs and RAM control
    always_comb begin
        busy      = (r_state != S_IDLE);
        o_done    = (r_state == S_DONE);
        ram_we    = 1'b0;
        ram_waddr = r_widx;
        ram_wdata = ram_rdata;
        ram_re    = 1'b0;
        unique case (r_state)
            S_SHIFT: begin
                ram_we = r_pend;
                ram_re = issue;
            end
            S_PUT: begin
                ram_we    = 1'b1;
                ram_waddr = r_pidx;
                ram_wdata = {r_code, r_pay};
            end
            S_SCAN: ram_re = issue;
            S_IDLE, S_DONE: ;
            default: ;
        endcase
    end

    always_comb begin
        o_result.ok             = r_ok;
        o_result.found_position = POS_W'(r_found);
        o_result.read_code      = r_rdata[DATA_W-1:PAYLOAD_BITS];
        o_result.read_payload   = 32'(r_rdata[PAYLOAD_BITS-1:0]);
        o_result.list_length    = POS_W'(r_count);
        o_result.is_empty       = (r_count == '0);
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
            r_left  <= '0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_pend <= 1'b0;
                unique case (t_op'(i_cmd.opcode))
                    OP_INSERT: r_left <= CNT_W'(cnt_c - pos_c + 1'b1);
                    OP_REMOVE: r_left <= CNT_W'(cnt_c - pos_c);
                    OP_FIND:   r_left <= r_count;
                    OP_READ:   r_left <= CNT_W'(1);
                endcase
            end else if (r_state == S_SHIFT || r_state == S_SCAN) begin
                r_pend <= issue;
                if (issue) begin
                    r_left <= r_left - 1'b1;
                end
            end
            if (r_state == S_PUT) begin
                r_count <= r_count + 1'b1;
            end else if (r_state == S_SHIFT && r_op == OP_REMOVE && !issue && !r_pend) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op    <= t_op'(i_cmd.opcode);
            r_code  <= i_cmd.record_code;
            r_pay   <= PAYLOAD_BITS'(i_cmd.record_payload);
            r_pidx  <= IDX_W'(pos_c - 1'b1);
            r_ok    <= 1'b0;
            r_found <= '0;
            r_rdata <= '0;
            unique case (t_op'(i_cmd.opcode))
                OP_INSERT: r_ridx <= IDX_W'(cnt_c - 1'b1);
                OP_REMOVE: r_ridx <= IDX_W'(pos_c);
                OP_FIND:   r_ridx <= '0;
                OP_READ:   r_ridx <= IDX_W'(pos_c - 1'b1);
            endcase
        end else begin
            if ((r_state == S_SHIFT || r_state == S_SCAN) && issue) begin
                unique case (r_op)
                    OP_INSERT: begin
                        r_ridx <= r_ridx - 1'b1;
                        r_widx <= r_ridx + 1'b1;
                    end
                    OP_REMOVE: begin
                        r_ridx <= r_ridx + 1'b1;
                        r_widx <= r_ridx - 1'b1;
                    end
                    OP_FIND, OP_READ: begin
                        r_ridx <= r_ridx + 1'b1;
                        r_widx <= r_ridx;
                    end
                endcase
            end
            if (r_state == S_PUT) begin
                r_ok <= 1'b1;
            end else if (r_state == S_SHIFT && r_op == OP_REMOVE && !issue && !r_pend) begin
                r_ok <= 1'b1;
            end else if (r_state == S_SCAN && hit) begin
                r_ok <= 1'b1;
                if (r_op == OP_FIND) begin
                    r_found <= CNT_W'(r_widx) + 1'b1;
                end else begin
                    r_rdata <= ram_rdata;
                end
            end
        end
    end

    `POLC_ASSERT_IMP(a_count_max, 1'b1, r_count <= CNT_W'(CAPACITY))
    `POLC_ASSERT_NXT(a_accept_busy, start && !busy, busy)
    `POLC_ASSERT_NXT(a_done_idle, o_done, !busy)
    `POLC_ASSERT_NXT(a_put_grows, r_state == S_PUT, r_count == $past(r_count) + 1'b1)
    `POLC_ASSERT_IMP(a_scan_no_write, r_state == S_SCAN, !ram_we)

endmodule

`default_nettype wire
